### rtl/cts_pkg.sv
package cts_pkg;

    localparam int NUM_TASKS   = 16;
    localparam int TICK_LENGTH = 10;
    localparam int MAX_OUT     = 16;

    localparam int SLOT_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int NRUN_W   = $clog2(MAX_OUT + 1);
    localparam int DIV_W    = 32;
    localparam int TICKS_W  = 29;
    localparam int TAG_W    = 8;
    localparam int PEND_W   = 8;
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 4;

    // Division by the tick length as a multiply by a rounded-up reciprocal.
    // With the shift set to the operand width plus ceil(log2(TICK_LENGTH)),
    // the quotient is exact for every 32-bit operand.
    localparam int REC_SHIFT = DIV_W + $clog2(TICK_LENGTH);
    localparam int REC_W     = DIV_W + 1;
    localparam int PROD_W    = DIV_W + REC_W;
    localparam logic [REC_W-1:0] REC_MULT =
        REC_W'(((64'd1 << REC_SHIFT) + 64'(TICK_LENGTH) - 64'd1) / 64'(TICK_LENGTH));

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_DISPATCH = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_RUN   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVD,
        S_DIVP,
        S_TICK,
        S_DISP,
        S_FIN
    } t_state;

endpackage

### rtl/cooperative_task_scheduler_core.sv
// Sequencing: delete clears the slot's valid bit, then finishes; tick visits the slots in order
// (one slot per cycle); add scales delay, then period, to ticks by one shared reciprocal multiplier;
// dispatch visits the slots in order and waits while the output side stalls.
// Throughput: one transaction at a time; o_in_stall is high until its last result is queued.
// Reset clears the state machine, the output valid bit and every slot's valid bit at once;
// there is no clearing pass.
module cooperative_task_scheduler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [cts_pkg::TAG_W-1:0]     i_task_tag,
    input  logic [cts_pkg::DIV_W-1:0]     i_delay_ms,
    input  logic [cts_pkg::DIV_W-1:0]     i_period_ms,
    input  logic [3:0]                    i_slot,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cts_pkg::KIND_W-1:0]    o_kind,
    output logic [cts_pkg::IDX_W-1:0]     o_slot_index,
    output logic [cts_pkg::TAG_W-1:0]     o_run_tag,
    output logic                          o_last
);
    import cts_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TASKS - 1);
    localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};
    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

    t_state r_state, n_state;

    // Slot table.
    logic [NUM_TASKS-1:0] r_valid, n_valid;
    logic [TAG_W-1:0]     r_tag_mem    [NUM_TASKS];
    logic [TICKS_W-1:0]   r_delay_mem  [NUM_TASKS];
    logic [TICKS_W-1:0]   r_period_mem [NUM_TASKS];
    logic [PEND_W-1:0]    r_pend_mem   [NUM_TASKS];

    logic                 wr_en;
    logic [TAG_W-1:0]     wr_tag;
    logic [TICKS_W-1:0]   wr_delay;
    logic [TICKS_W-1:0]   wr_period;
    logic [PEND_W-1:0]    wr_pend;

    // Sequencer registers.
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [NRUN_W-1:0]    r_nrun, n_nrun;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIV_W-1:0]     r_per_ms, n_per_ms;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic [TICKS_W-1:0]   r_delay_t, n_delay_t;

    // Result waiting to be queued; a dispatch run is held until the next one
    // is found so that its last flag is known.
    logic                 r_hold_valid, n_hold_valid;
    t_kind                r_hold_kind, n_hold_kind;
    logic [IDX_W-1:0]     r_hold_idx, n_hold_idx;
    logic [TAG_W-1:0]     r_hold_tag, n_hold_tag;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    t_kind                r_out_kind, n_out_kind;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;
    logic [TAG_W-1:0]     r_out_tag, n_out_tag;
    logic                 r_out_last, n_out_last;

    logic                 rd_valid;
    logic [TAG_W-1:0]     rd_tag;
    logic [TICKS_W-1:0]   rd_delay;
    logic [TICKS_W-1:0]   rd_period;
    logic [PEND_W-1:0]    rd_pend;

    logic                 free_any;
    logic [SLOT_W-1:0]    free_idx;
    logic                 out_free;
    logic                 in_acc;

    logic [PROD_W-1:0]    mul_prod;
    logic [DIV_W-1:0]     mul_q;

    function automatic logic [TICKS_W-1:0] sat_ticks(input logic [DIV_W-1:0] q);
        logic [TICKS_W-1:0] res;
        res = (q > DIV_W'(TICKS_MAX)) ? TICKS_MAX : q[TICKS_W-1:0];
        return res;
    endfunction

    // An invalid slot always reads as cleared.
    assign rd_valid  = r_valid[r_idx];
    assign rd_tag    = rd_valid ? r_tag_mem[r_idx]    : '0;
    assign rd_delay  = rd_valid ? r_delay_mem[r_idx]  : '0;
    assign rd_period = rd_valid ? r_period_mem[r_idx] : '0;
    assign rd_pend   = rd_valid ? r_pend_mem[r_idx]   : '0;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Shared reciprocal multiplier: divides the operand by the tick length.
    assign mul_prod = {{REC_W{1'b0}}, r_quo} * {{DIV_W{1'b0}}, REC_MULT};
    assign mul_q    = DIV_W'(mul_prod >> REC_SHIFT);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_idx        = r_idx;
        n_nrun       = r_nrun;
        n_quo        = r_quo;
        n_per_ms     = r_per_ms;
        n_tag        = r_tag;
        n_delay_t    = r_delay_t;
        n_hold_valid = r_hold_valid;
        n_hold_kind  = r_hold_kind;
        n_hold_idx   = r_hold_idx;
        n_hold_tag   = r_hold_tag;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_kind   = r_out_kind;
        n_out_idx    = r_out_idx;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_tag       = rd_tag;
        wr_delay     = rd_delay;
        wr_period    = rd_period;
        wr_pend      = rd_pend;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_hold_valid = 1'b0;
                    n_idx        = '0;
                    n_nrun       = '0;
                    case (t_mode'(i_mode))
                        MODE_ADD: begin
                            if (free_any) begin
                                n_idx    = free_idx;
                                n_quo    = i_delay_ms;
                                n_tag    = i_task_tag;
                                n_per_ms = i_period_ms;
                                n_state  = S_DIVD;
                            end else begin
                                n_hold_valid = 1'b1;
                                n_hold_kind  = KIND_FULL;
                                n_hold_idx   = '0;
                                n_hold_tag   = '0;
                                n_state      = S_FIN;
                            end
                        end
                        MODE_DELETE: begin
                            if (32'(i_slot) < NUM_TASKS) begin
                                n_valid[i_slot[SLOT_W-1:0]] = 1'b0;
                            end
                            n_state = S_FIN;
                        end
                        MODE_TICK: begin
                            n_state = S_TICK;
                        end
                        MODE_DISPATCH: begin
                            n_state = S_DISP;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DIVD: begin
                n_delay_t = sat_ticks(mul_q);
                n_quo     = r_per_ms;
                n_state   = S_DIVP;
            end
            S_DIVP: begin
                wr_en          = 1'b1;
                wr_tag         = r_tag;
                wr_delay       = r_delay_t;
                wr_period      = sat_ticks(mul_q);
                wr_pend        = '0;
                n_valid[r_idx] = 1'b1;
                n_hold_valid   = 1'b1;
                n_hold_kind    = KIND_ADDED;
                n_hold_idx     = IDX_W'(r_idx);
                n_hold_tag     = '0;
                n_state        = S_FIN;
            end
            S_TICK: begin
                if (rd_valid) begin
                    wr_en = 1'b1;
                    if (rd_delay == '0) begin
                        if (rd_pend != PEND_MAX) begin
                            wr_pend = rd_pend + 1'b1;
                        end
                        if (rd_period != '0) begin
                            wr_delay = rd_period;
                        end
                    end else begin
                        wr_delay = rd_delay - 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = S_FIN;
                end
            end
            S_DISP: begin
                if (r_nrun == NRUN_W'(MAX_OUT)) begin
                    n_state = S_FIN;
                end else if (rd_pend != '0 && r_hold_valid && !out_free) begin
                    n_state = S_DISP;
                end else begin
                    if (rd_pend != '0) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_hold_kind;
                            n_out_idx   = r_hold_idx;
                            n_out_tag   = r_hold_tag;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_kind  = KIND_RUN;
                        n_hold_idx   = IDX_W'(r_idx);
                        n_hold_tag   = rd_tag;
                        n_nrun       = r_nrun + 1'b1;
                        if (rd_period == '0) begin
                            n_valid[r_idx] = 1'b0;
                        end else begin
                            wr_en   = 1'b1;
                            wr_pend = rd_pend - 1'b1;
                        end
                    end
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_hold_valid ? r_hold_kind : KIND_DONE;
                    n_out_idx    = r_hold_valid ? r_hold_idx : '0;
                    n_out_tag    = r_hold_valid ? r_hold_tag : '0;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_nrun       <= '0;
        end else begin
            r_valid      <= n_valid;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            r_nrun       <= n_nrun;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_quo       <= n_quo;
        r_per_ms    <= n_per_ms;
        r_tag       <= n_tag;
        r_delay_t   <= n_delay_t;
        r_hold_kind <= n_hold_kind;
        r_hold_idx  <= n_hold_idx;
        r_hold_tag  <= n_hold_tag;
        r_out_kind  <= n_out_kind;
        r_out_idx   <= n_out_idx;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tag_mem[r_idx]    <= wr_tag;
            r_delay_mem[r_idx]  <= wr_delay;
            r_period_mem[r_idx] <= wr_period;
            r_pend_mem[r_idx]   <= wr_pend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_slot_index = r_out_idx;
    assign o_run_tag    = r_out_tag;
    assign o_last       = r_out_last;

    // The dispatch run count never passes the per-transaction limit.
    a_nrun_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrun <= NRUN_W'(MAX_OUT))
        else $error("dispatch run count out of range");

    // The slot chosen for an add stays free while its times are divided.
    a_div_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVD || r_state == S_DIVP) |-> !r_valid[r_idx])
        else $error("slot taken during divide");

    // A held run result only exists while a dispatch is in progress.
    a_hold_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_valid && r_hold_kind == KIND_RUN) |-> (r_state == S_DISP || r_state == S_FIN))
        else $error("run result held outside dispatch");

    // Returning to idle always queues the final result of the transaction.
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_FIN && r_state == S_IDLE) |-> (r_out_valid && r_out_last))
        else $error("transaction ended without final result");

endmodule
